### design/nir_pkg.sv
// Shared types, constants and helper functions for the NEC IR interval decoder.
`default_nettype none

package nir_pkg;

    localparam int unsigned CFG_WIDTH   = 16;
    localparam int unsigned IDX_WIDTH   = 3;
    localparam int unsigned IV_WIDTH    = 16;
    localparam int unsigned FRAME_WIDTH = 32;
    localparam int unsigned CNT_WIDTH   = 5;

    localparam logic [CFG_WIDTH-1:0] START_TARGET_RST  = 16'd13500;
    localparam logic [CFG_WIDTH-1:0] START_TOL_RST     = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] REPEAT_TARGET_RST = 16'd11250;
    localparam logic [CFG_WIDTH-1:0] REPEAT_TOL_RST    = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] ZERO_TARGET_RST   = 16'd1125;
    localparam logic [CFG_WIDTH-1:0] ONE_TARGET_RST    = 16'd2250;
    localparam logic [CFG_WIDTH-1:0] BIT_TOL_RST       = 16'd300;

    localparam logic [CNT_WIDTH-1:0] LAST_BIT = 5'd31;

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_START_TARGET  = 3'd0,
        REG_START_TOL     = 3'd1,
        REG_REPEAT_TARGET = 3'd2,
        REG_REPEAT_TOL    = 3'd3,
        REG_ZERO_TARGET   = 3'd4,
        REG_ONE_TARGET    = 3'd5,
        REG_BIT_TOL       = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_FRAME  = 2'd1,
        ST_REPEAT = 2'd2,
        ST_ERROR  = 2'd3
    } status_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] start_target;
        logic [CFG_WIDTH-1:0] start_tolerance;
        logic [CFG_WIDTH-1:0] repeat_target;
        logic [CFG_WIDTH-1:0] repeat_tolerance;
        logic [CFG_WIDTH-1:0] zero_target;
        logic [CFG_WIDTH-1:0] one_target;
        logic [CFG_WIDTH-1:0] bit_tolerance;
    } cfg_t;

    typedef struct packed {
        logic is_start;
        logic is_repeat;
        logic is_zero;
        logic is_one;
    } win_t;

    function automatic logic nir_in_window(
        input logic [IV_WIDTH-1:0]  v,
        input logic [CFG_WIDTH-1:0] target,
        input logic [CFG_WIDTH-1:0] tol
    );
        logic [CFG_WIDTH-1:0] diff;
        diff = (v >= target) ? (v - target) : (target - v);
        return diff <= tol;
    endfunction

    function automatic logic nir_check(input logic [FRAME_WIDTH-1:0] w);
        return (w[7:0] == ~w[15:8]) && (w[23:16] == ~w[31:24]);
    endfunction

endpackage

`default_nettype wire

### design/nir_cfg.sv
// Configuration register file holding the window targets and tolerances.
`default_nettype none

module nir_cfg
    import nir_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [IDX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_START_TARGET:  cfg_next.start_target     = cfg_data;
                REG_START_TOL:     cfg_next.start_tolerance  = cfg_data;
                REG_REPEAT_TARGET: cfg_next.repeat_target    = cfg_data;
                REG_REPEAT_TOL:    cfg_next.repeat_tolerance = cfg_data;
                REG_ZERO_TARGET:   cfg_next.zero_target      = cfg_data;
                REG_ONE_TARGET:    cfg_next.one_target       = cfg_data;
                REG_BIT_TOL:       cfg_next.bit_tolerance    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_target     <= START_TARGET_RST;
            cfg_reg.start_tolerance  <= START_TOL_RST;
            cfg_reg.repeat_target    <= REPEAT_TARGET_RST;
            cfg_reg.repeat_tolerance <= REPEAT_TOL_RST;
            cfg_reg.zero_target      <= ZERO_TARGET_RST;
            cfg_reg.one_target       <= ONE_TARGET_RST;
            cfg_reg.bit_tolerance    <= BIT_TOL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/nir_classify.sv
// Window classifier that compares one interval against the four timing windows.
`default_nettype none

module nir_classify
    import nir_pkg::*;
(
    input  wire logic [IV_WIDTH-1:0] interval,
    input  cfg_t                     cfg,
    output win_t                     win
);

    always_comb
    begin
        win.is_start  = nir_in_window(interval, cfg.start_target, cfg.start_tolerance);
        win.is_repeat = nir_in_window(interval, cfg.repeat_target, cfg.repeat_tolerance);
        win.is_zero   = nir_in_window(interval, cfg.zero_target, cfg.bit_tolerance);
        win.is_one    = nir_in_window(interval, cfg.one_target, cfg.bit_tolerance);
    end

endmodule

`default_nettype wire

### design/nir_core.sv
// Frame collection state, repeat memory and the registered result stage.
`default_nettype none

module nir_core
    import nir_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    input  win_t                        win,
    output logic                        out_free,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  status,
    output logic [FRAME_WIDTH-1:0]      frame_word,
    output logic                        frame_ok,
    output logic [7:0]                  address,
    output logic [7:0]                  command_byte
);

    logic [FRAME_WIDTH-1:0] shift_reg;
    logic [FRAME_WIDTH-1:0] shift_next;
    logic [CNT_WIDTH-1:0]   cnt_reg;
    logic [CNT_WIDTH-1:0]   cnt_next;
    logic                   coll_reg;
    logic                   coll_next;
    logic [FRAME_WIDTH-1:0] last_reg;
    logic [FRAME_WIDTH-1:0] last_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    status_t                status_reg;
    status_t                status_next;
    logic [FRAME_WIDTH-1:0] word_reg;
    logic [FRAME_WIDTH-1:0] word_next;
    logic                   ok_reg;

    logic                   take;
    logic [FRAME_WIDTH-1:0] shifted;

    assign out_free = !out_valid_reg || !out_stall;
    assign take     = item_valid && out_free;
    assign shifted  = shift_reg | (FRAME_WIDTH'(win.is_one && !win.is_zero) << cnt_reg);

    always_comb
    begin
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        coll_next   = coll_reg;
        last_next   = last_reg;
        status_next = ST_NONE;
        word_next   = '0;
        if (win.is_start)
        begin
            shift_next = '0;
            cnt_next   = '0;
            coll_next  = 1'b1;
        end
        else if (win.is_repeat)
        begin
            if (last_reg != '0)
            begin
                status_next = ST_REPEAT;
                word_next   = last_reg;
            end
            else
            begin
                status_next = ST_ERROR;
            end
        end
        else if (coll_reg)
        begin
            if (win.is_zero || win.is_one)
            begin
                if (cnt_reg == LAST_BIT)
                begin
                    status_next = ST_FRAME;
                    word_next   = shifted;
                    shift_next  = '0;
                    cnt_next    = '0;
                    coll_next   = 1'b0;
                    last_next   = nir_check(shifted) ? shifted : '0;
                end
                else
                begin
                    shift_next = shifted;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            else
            begin
                status_next = ST_ERROR;
                shift_next  = '0;
                cnt_next    = '0;
                coll_next   = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            cnt_reg       <= '0;
            coll_reg      <= 1'b0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                shift_reg <= shift_next;
                cnt_reg   <= cnt_next;
                coll_reg  <= coll_next;
                last_reg  <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg <= status_next;
            word_reg   <= word_next;
            ok_reg     <= nir_check(word_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign frame_word   = word_reg;
    assign frame_ok     = ok_reg;
    assign address      = word_reg[7:0];
    assign command_byte = word_reg[23:16];

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !coll_reg |-> (cnt_reg == '0 && shift_reg == '0))
        else $error("Idle decoder holds partial frame bits.");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (last_reg != '0) |-> nir_check(last_reg))
        else $error("Remembered frame fails its complement check.");

    a_repeat_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_REPEAT) |-> ok_reg)
        else $error("Repeat transaction carries an invalid frame.");

    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_NONE || status_reg == ST_ERROR))
            |-> (word_reg == '0))
        else $error("Transaction without a frame carries a nonzero word.");

endmodule

`default_nettype wire

### design/nec_ir_interval_decoder.sv
// Top level of the NEC IR interval decoder: input register and block wiring.
// A result passes through the interval register and then the registered result stage.
// Throughput: one interval per cycle while the result side does not stall.
// The interval register feeds the window compares and the frame update directly.
// Reset restores the default windows, clears any partial frame and forgets
// the remembered frame; both pipeline stages come up empty.
`default_nettype none

module nec_ir_interval_decoder
    import nir_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [IDX_WIDTH-1:0]   cfg_index,
    input  wire logic [CFG_WIDTH-1:0]   cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [IV_WIDTH-1:0]    edge_gap,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  status,
    output logic [FRAME_WIDTH-1:0]      frame_word,
    output logic                        frame_ok,
    output logic [7:0]                  address,
    output logic [7:0]                  command_byte
);

    cfg_t                cfg;
    win_t                win;
    logic                out_free;
    logic                iv_valid_reg;
    logic                iv_valid_next;
    logic [IV_WIDTH-1:0] iv_reg;

    assign in_stall      = iv_valid_reg && !out_free;
    assign iv_valid_next = in_stall ? iv_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_valid_reg <= 1'b0;
        end
        else
        begin
            iv_valid_reg <= iv_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            iv_reg <= edge_gap;
        end
    end

    nir_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nir_classify u_classify (
        .interval (iv_reg),
        .cfg      (cfg),
        .win      (win)
    );

    nir_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (iv_valid_reg),
        .win          (win),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .frame_word   (frame_word),
        .frame_ok     (frame_ok),
        .address      (address),
        .command_byte (command_byte)
    );

endmodule

`default_nettype wire

### sim/nec_ir_interval_decoder_tb.sv
// Self-checking testbench for the NEC IR interval decoder with its own decode predictor.
`timescale 1ns / 100ps

module nec_ir_interval_decoder_tb
    import nir_pkg::*;
();

    localparam logic [IDX_WIDTH-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int FRAME_BITS = 32;

    typedef struct {
        status_t    status;
        logic [31:0] word;
        logic       ok;
        logic [7:0] addr;
        logic [7:0] cmd;
    } ir_result_t;

    typedef struct {
        logic [15:0] iv;
        bit          typed;
        status_t     st;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [IDX_WIDTH-1:0]   cfg_index = '0;
    logic [CFG_WIDTH-1:0]   cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [IV_WIDTH-1:0]    edge_gap = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             status;
    logic [FRAME_WIDTH-1:0] frame_word;
    logic                   frame_ok;
    logic [7:0]             address;
    logic [7:0]             command_byte;

    cfg_t        windows;
    logic [31:0] shift_bits;
    int          bits_taken;
    bit          collecting;
    logic [31:0] last_good;

    ir_result_t    pending_results[$];
    ir_result_t    front_result;
    directed_row_t directed_rows[25];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            sent_count = 0;
    int            burst_left = 0;
    int            stall_mode = 0;
    int            stall_left = 0;
    int            stall_period = 4;

    nec_ir_interval_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .edge_gap     (edge_gap),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .frame_word   (frame_word),
        .frame_ok     (frame_ok),
        .address      (address),
        .command_byte (command_byte)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit hits_window(input logic [15:0] v, input logic [15:0] target,
                                       input logic [15:0] tol);
        int d;
        d = int'(v) - int'(target);
        if (d < 0)
        begin
            d = -d;
        end
        return d <= int'(tol);
    endfunction

    function automatic bit pair_check(input logic [31:0] w);
        logic [7:0] a_inv;
        logic [7:0] c_inv;
        a_inv = ~w[15:8];
        c_inv = ~w[31:24];
        return (w[7:0] == a_inv) && (w[23:16] == c_inv);
    endfunction

    function automatic ir_result_t make_result(input status_t st, input logic [31:0] w);
        ir_result_t r;
        r.status = st;
        r.word   = w;
        r.ok     = pair_check(w);
        r.addr   = w[7:0];
        r.cmd    = w[23:16];
        return r;
    endfunction

    function automatic ir_result_t decode_interval(input logic [15:0] iv);
        logic        b;
        logic [31:0] w;
        if (hits_window(iv, windows.start_target, windows.start_tolerance))
        begin
            shift_bits = '0;
            bits_taken = 0;
            collecting = 1'b1;
            return make_result(ST_NONE, '0);
        end
        if (hits_window(iv, windows.repeat_target, windows.repeat_tolerance))
        begin
            if (last_good != '0)
            begin
                return make_result(ST_REPEAT, last_good);
            end
            return make_result(ST_ERROR, '0);
        end
        if (!collecting)
        begin
            return make_result(ST_NONE, '0);
        end
        if (hits_window(iv, windows.zero_target, windows.bit_tolerance))
        begin
            b = 1'b0;
        end
        else if (hits_window(iv, windows.one_target, windows.bit_tolerance))
        begin
            b = 1'b1;
        end
        else
        begin
            shift_bits = '0;
            bits_taken = 0;
            collecting = 1'b0;
            return make_result(ST_ERROR, '0);
        end
        shift_bits[bits_taken] = b;
        bits_taken++;
        if (bits_taken < FRAME_BITS)
        begin
            return make_result(ST_NONE, '0);
        end
        w = shift_bits;
        shift_bits = '0;
        bits_taken = 0;
        collecting = 1'b0;
        last_good = pair_check(w) ? w : '0;
        return make_result(ST_FRAME, w);
    endfunction

    function automatic logic [15:0] pick_in(input int target, input int tol);
        int lo;
        int hi;
        lo = target - tol;
        hi = target + tol;
        if (lo < 0)
        begin
            lo = 0;
        end
        if (hi > 65535)
        begin
            hi = 65535;
        end
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [15:0] noise_interval();
        int t;
        int tol;
        int v;
        case ($urandom_range(0, 5))
            0: t = windows.start_target;
            1: t = windows.repeat_target;
            2: t = windows.zero_target;
            default: t = windows.one_target;
        endcase
        case ($urandom_range(0, 5))
            0: tol = windows.start_tolerance;
            1: tol = windows.repeat_tolerance;
            default: tol = windows.bit_tolerance;
        endcase
        case ($urandom_range(0, 7))
            0: v = t - tol - 1;
            1: v = t - tol;
            2: v = t + tol;
            3: v = t + tol + 1;
            4: v = 0;
            5: v = 65535;
            default: v = $urandom_range(0, 65535);
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 65535)
        begin
            v = 65535;
        end
        return 16'(v);
    endfunction

    task automatic send_interval(input logic [15:0] iv, input bit typed = 1'b0,
                                 input status_t typed_st = ST_NONE);
        ir_result_t predicted;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        edge_gap <= iv;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted = decode_interval(iv);
        pending_results.push_back(typed ? make_result(typed_st, '0) : predicted);
        sent_count++;
        burst_left--;
    endtask

    task automatic send_frame();
        logic [7:0]  a;
        logic [7:0]  c;
        logic [31:0] w;
        int cut;
        int i;
        a = 8'($urandom_range(0, 255));
        c = 8'($urandom_range(0, 255));
        w = ($urandom_range(0, 3) != 0) ? {~c, c, ~a, a} : 32'($urandom);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : FRAME_BITS;
        send_interval(pick_in(windows.start_target, windows.start_tolerance));
        for (i = 0; i < FRAME_BITS; i++)
        begin
            if (i == cut)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_interval(pick_in(windows.start_target, windows.start_tolerance));
                end
                else
                begin
                    send_interval(noise_interval());
                end
                return;
            end
            send_interval(w[i] ? pick_in(windows.one_target, windows.bit_tolerance)
                               : pick_in(windows.zero_target, windows.bit_tolerance));
        end
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        int r;
        int k;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                send_frame();
                for (k = $urandom_range(0, 3); k > 0; k--)
                begin
                    send_interval(pick_in(windows.repeat_target, windows.repeat_tolerance));
                end
            end
            else if (r < 80)
            begin
                send_interval(pick_in(windows.repeat_target, windows.repeat_tolerance));
            end
            else
            begin
                send_interval(noise_interval());
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_windows(input cfg_t c);
        write_reg(REG_START_TARGET, c.start_target);
        write_reg(REG_START_TOL, c.start_tolerance);
        write_reg(REG_REPEAT_TARGET, c.repeat_target);
        write_reg(REG_REPEAT_TOL, c.repeat_tolerance);
        write_reg(REG_ZERO_TARGET, c.zero_target);
        write_reg(REG_ONE_TARGET, c.one_target);
        write_reg(REG_BIT_TOL, c.bit_tolerance);
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
        windows = c;
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode   = $urandom_range(0, 3);
            stall_left   = $urandom_range(20, 200);
            stall_period = $urandom_range(2, 7);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ((cycle_count % stall_period) == 0);
            default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < 10)
                begin
                    $display("unexpected result: status=%0d word=%h", status, frame_word);
                end
                mismatch_count++;
            end
            else
            begin
                front_result = pending_results.pop_front();
                if (status !== front_result.status || frame_word !== front_result.word ||
                    frame_ok !== front_result.ok || address !== front_result.addr ||
                    command_byte !== front_result.cmd)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("mismatch: expected status=%0d word=%h ok=%0d addr=%h cmd=%h",
                                 front_result.status, front_result.word, front_result.ok,
                                 front_result.addr, front_result.cmd);
                        $display("          actual   status=%0d word=%h ok=%0d addr=%h cmd=%h",
                                 status, frame_word, frame_ok, address, command_byte);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        windows = '{start_target: START_TARGET_RST, start_tolerance: START_TOL_RST,
                    repeat_target: REPEAT_TARGET_RST, repeat_tolerance: REPEAT_TOL_RST,
                    zero_target: ZERO_TARGET_RST, one_target: ONE_TARGET_RST,
                    bit_tolerance: BIT_TOL_RST};
        shift_bits = '0;
        bits_taken = 0;
        collecting = 1'b0;
        last_good  = '0;

        directed_rows = '{
            '{16'd0,     1'b1, ST_NONE},
            '{16'd65535, 1'b1, ST_NONE},
            '{16'd11250, 1'b1, ST_ERROR},
            '{16'd10250, 1'b1, ST_ERROR},
            '{16'd12250, 1'b1, ST_ERROR},
            '{16'd1125,  1'b1, ST_NONE},
            '{16'd13500, 1'b1, ST_NONE},
            '{16'd1125,  1'b1, ST_NONE},
            '{16'd2250,  1'b1, ST_NONE},
            '{16'd825,   1'b1, ST_NONE},
            '{16'd2550,  1'b1, ST_NONE},
            '{16'd11250, 1'b0, ST_NONE},
            '{16'd1425,  1'b0, ST_NONE},
            '{16'd12500, 1'b1, ST_NONE},
            '{16'd1950,  1'b0, ST_NONE},
            '{16'd1700,  1'b1, ST_ERROR},
            '{16'd2250,  1'b1, ST_NONE},
            '{16'd14500, 1'b1, ST_NONE},
            '{16'd14501, 1'b1, ST_ERROR},
            '{16'd10249, 1'b1, ST_NONE},
            '{16'd12251, 1'b1, ST_NONE},
            '{16'd13500, 1'b1, ST_NONE},
            '{16'd0,     1'b1, ST_ERROR},
            '{16'd13500, 1'b1, ST_NONE},
            '{16'd65535, 1'b1, ST_ERROR}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_interval(directed_rows[i].iv, directed_rows[i].typed, directed_rows[i].st);
        end
        run_random(400);

        // Zero tolerances: only exact targets match.
        drain();
        apply_windows('{start_target: 16'd13500, start_tolerance: 16'd0,
                        repeat_target: 16'd11250, repeat_tolerance: 16'd0,
                        zero_target: 16'd562, one_target: 16'd1687, bit_tolerance: 16'd0});
        run_random(250);

        // Overlapping windows, so the priority order decides.
        drain();
        apply_windows('{start_target: 16'd3000, start_tolerance: 16'd1000,
                        repeat_target: 16'd2500, repeat_tolerance: 16'd1000,
                        zero_target: 16'd1000, one_target: 16'd1800, bit_tolerance: 16'd600});
        run_random(300);

        // Targets at both ends of the range.
        drain();
        apply_windows('{start_target: 16'd65535, start_tolerance: 16'd200,
                        repeat_target: 16'd0, repeat_tolerance: 16'd100,
                        zero_target: 16'd300, one_target: 16'd65000, bit_tolerance: 16'd500});
        run_random(250);

        drain();
        apply_windows('{start_target: 16'd40000, start_tolerance: 16'd0,
                        repeat_target: 16'd20000, repeat_tolerance: 16'd0,
                        zero_target: 16'd0, one_target: 16'd65535, bit_tolerance: 16'd65535});
        run_random(200);

        // Every interval is a start.
        drain();
        apply_windows('{start_target: 16'd0, start_tolerance: 16'd65535,
                        repeat_target: 16'd65535, repeat_tolerance: 16'd65535,
                        zero_target: 16'd1125, one_target: 16'd2250, bit_tolerance: 16'd300});
        run_random(60);

        drain();
        apply_windows('{start_target: 16'($urandom), start_tolerance: 16'($urandom_range(0, 3000)),
                        repeat_target: 16'($urandom), repeat_tolerance: 16'($urandom_range(0, 3000)),
                        zero_target: 16'($urandom), one_target: 16'($urandom),
                        bit_tolerance: 16'($urandom_range(0, 3000))});
        run_random(200);

        drain();
        apply_windows('{start_target: START_TARGET_RST, start_tolerance: START_TOL_RST,
                        repeat_target: REPEAT_TARGET_RST, repeat_tolerance: REPEAT_TOL_RST,
                        zero_target: ZERO_TARGET_RST, one_target: ONE_TARGET_RST,
                        bit_tolerance: BIT_TOL_RST});
        run_random(170);

        drain();
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
